// ===== hw/rtl/tss_pkg.sv =====
// Shared constants, item and status types for the thick segment stroker.
`timescale 1ns / 1ps
package tss_pkg;

    // Defaults for the top-level parameters.
    localparam int COORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 8;

    // Widest coordinate the design supports; points are carried at this width.
    localparam int COORD_MAX  = 32;
    // Direction vectors: difference of two coordinates.
    localparam int VEC_BITS   = COORD_MAX + 1;
    // Unit vectors: signed, 14 fraction bits.
    localparam int UNIT_FRAC  = 14;
    localparam int UNIT_BITS  = UNIT_FRAC + 2;
    // Stroke width: unsigned Q8.8.
    localparam int WIDTH_BITS = 16;
    localparam int WIDTH_FRAC = 8;
    localparam int RGBA_BITS  = 32;

    // Normalizer datapath widths.
    localparam int RED_BITS   = 31;
    localparam int SQ_BITS    = 2 * RED_BITS + 1;
    localparam int LEN_BITS   = RED_BITS + 1;
    localparam int NUM_BITS   = RED_BITS + UNIT_FRAC + 1;
    localparam int Q_BITS     = UNIT_FRAC + 1;
    localparam int CNT_BITS   = $clog2(Q_BITS);

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Vertices per segment.
    localparam int VERTS      = 6;
    localparam int VCNT_BITS  = $clog2(VERTS);

    // Configuration register indexes.
    localparam int REG_IDX_BITS = 2;
    localparam logic [REG_IDX_BITS-1:0] REG_OFFSET_X = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_OFFSET_Y = 2'd1;

    // Segment kinds.
    localparam logic KIND_PLAIN     = 1'b0;
    localparam logic KIND_CONNECTED = 1'b1;

    // One classified segment as it waits in the queue.
    typedef struct packed {
        logic                          kind;
        logic signed [COORD_MAX-1:0]   p1x;
        logic signed [COORD_MAX-1:0]   p1y;
        logic signed [COORD_MAX-1:0]   p2x;
        logic signed [COORD_MAX-1:0]   p2y;
        logic signed [VEC_BITS-1:0]    d0x;
        logic signed [VEC_BITS-1:0]    d0y;
        logic signed [VEC_BITS-1:0]    d1x;
        logic signed [VEC_BITS-1:0]    d1y;
        logic signed [VEC_BITS-1:0]    d2x;
        logic signed [VEC_BITS-1:0]    d2y;
        logic [WIDTH_BITS-1:0]         width;
        logic [RGBA_BITS-1:0]          rgba;
    } item_t;

    // Status and result of the normalizer.
    typedef struct packed {
        logic                          done;
        logic                          nonzero;
        logic signed [UNIT_BITS-1:0]   ux;
        logic signed [UNIT_BITS-1:0]   uy;
    } norm_result_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SQX,
        N_SQY,
        N_ROOT,
        N_PREP,
        N_DIV,
        N_DONE
    } norm_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_KICK,
        B_WAIT,
        B_HALF,
        B_EMIT
    } back_state_t;

endpackage

// ===== hw/rtl/tss_norm.sv =====
// Iterative unit-vector unit: integer square root and two restoring dividers.
`timescale 1ns / 1ps
module tss_norm
    import tss_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [VEC_BITS-1:0] vec_x,
    input  logic signed [VEC_BITS-1:0] vec_y,
    output norm_result_t               result
);

    norm_state_t state_reg;
    norm_state_t state_next;

    logic [RED_BITS-1:0]  ax_reg;
    logic [RED_BITS-1:0]  ay_reg;
    logic                 negx_reg;
    logic                 negy_reg;
    logic                 nonzero_reg;
    logic [SQ_BITS-1:0]   acc_reg;
    logic [SQ_BITS-1:0]   root_reg;
    logic [SQ_BITS-1:0]   bit_reg;
    logic [NUM_BITS-1:0]  remx_reg;
    logic [NUM_BITS-1:0]  remy_reg;
    logic [NUM_BITS-1:0]  dvs_reg;
    logic [Q_BITS-1:0]    qx_reg;
    logic [Q_BITS-1:0]    qy_reg;
    logic [CNT_BITS-1:0]  cnt_reg;

    logic [VEC_BITS-1:0]  mag_x;
    logic [VEC_BITS-1:0]  mag_y;
    logic [VEC_BITS-1:0]  mag_or;
    logic [VEC_BITS-1:0]  red_x;
    logic [VEC_BITS-1:0]  red_y;
    logic                 is_zero;
    logic [SQ_BITS:0]     trial;
    logic                 root_ge;
    logic [LEN_BITS-1:0]  len;
    logic                 gex;
    logic                 gey;
    logic [2*RED_BITS-1:0] sq_x;
    logic [2*RED_BITS-1:0] sq_y;

    // Magnitudes, scaled down together until both fit the squarer.
    always_comb
    begin
        mag_x   = vec_x[VEC_BITS-1] ? VEC_BITS'(-vec_x) : VEC_BITS'(vec_x);
        mag_y   = vec_y[VEC_BITS-1] ? VEC_BITS'(-vec_y) : VEC_BITS'(vec_y);
        mag_or  = mag_x | mag_y;
        is_zero = (mag_or == '0);
        if (mag_or[VEC_BITS-1])
        begin
            red_x = mag_x >> 2;
            red_y = mag_y >> 2;
        end
        else if (mag_or[VEC_BITS-2])
        begin
            red_x = mag_x >> 1;
            red_y = mag_y >> 1;
        end
        else
        begin
            red_x = mag_x;
            red_y = mag_y;
        end
    end

    // Full-width squares of the reduced magnitudes.
    always_comb
    begin
        sq_x = ax_reg * ax_reg;
        sq_y = ay_reg * ay_reg;
    end

    // One root bit and one quotient bit per cycle.
    always_comb
    begin
        trial   = (SQ_BITS + 1)'(root_reg) + (SQ_BITS + 1)'(bit_reg);
        root_ge = ((SQ_BITS + 1)'(acc_reg) >= trial);
        len     = root_reg[LEN_BITS-1:0];
        gex     = (remx_reg >= dvs_reg);
        gey     = (remy_reg >= dvs_reg);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    state_next = is_zero ? N_DONE : N_SQX;
                end
            end
            N_SQX:  state_next = N_SQY;
            N_SQY:  state_next = N_ROOT;
            N_ROOT:
            begin
                if (bit_reg[0])
                begin
                    state_next = N_PREP;
                end
            end
            N_PREP: state_next = N_DIV;
            N_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = N_DONE;
                end
            end
            N_DONE: state_next = N_IDLE;
            default: state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            N_IDLE:
            begin
                ax_reg      <= red_x[RED_BITS-1:0];
                ay_reg      <= red_y[RED_BITS-1:0];
                negx_reg    <= vec_x[VEC_BITS-1];
                negy_reg    <= vec_y[VEC_BITS-1];
                nonzero_reg <= !is_zero;
                qx_reg      <= '0;
                qy_reg      <= '0;
            end
            N_SQX:
            begin
                acc_reg <= SQ_BITS'(sq_x);
            end
            N_SQY:
            begin
                acc_reg  <= acc_reg + SQ_BITS'(sq_y);
                root_reg <= '0;
                bit_reg  <= SQ_BITS'(1) << (SQ_BITS - 1);
            end
            N_ROOT:
            begin
                if (root_ge)
                begin
                    acc_reg  <= acc_reg - trial[SQ_BITS-1:0];
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            N_PREP:
            begin
                remx_reg <= (NUM_BITS'(ax_reg) << UNIT_FRAC) + NUM_BITS'(len >> 1);
                remy_reg <= (NUM_BITS'(ay_reg) << UNIT_FRAC) + NUM_BITS'(len >> 1);
                dvs_reg  <= NUM_BITS'(len) << UNIT_FRAC;
                cnt_reg  <= CNT_BITS'(UNIT_FRAC);
            end
            N_DIV:
            begin
                if (gex)
                begin
                    remx_reg <= remx_reg - dvs_reg;
                end
                if (gey)
                begin
                    remy_reg <= remy_reg - dvs_reg;
                end
                qx_reg  <= {qx_reg[Q_BITS-2:0], gex};
                qy_reg  <= {qy_reg[Q_BITS-2:0], gey};
                dvs_reg <= dvs_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Signed result, valid while done is high.
    always_comb
    begin
        result.done    = (state_reg == N_DONE);
        result.nonzero = nonzero_reg;
        result.ux      = negx_reg ? -UNIT_BITS'(qx_reg) : UNIT_BITS'(qx_reg);
        result.uy      = negy_reg ? -UNIT_BITS'(qy_reg) : UNIT_BITS'(qy_reg);
    end

endmodule

// ===== hw/rtl/tss_front.sv =====
// Front end: takes input beats, forms direction vectors and pushes the queue.
`timescale 1ns / 1ps
module tss_front
    import tss_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         valid,
    output logic                         ready,
    input  logic                         kind,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic signed [COORD_BITS-1:0] before_x,
    input  logic signed [COORD_BITS-1:0] before_y,
    input  logic signed [COORD_BITS-1:0] after_x,
    input  logic signed [COORD_BITS-1:0] after_y,
    input  logic [WIDTH_BITS-1:0]        stroke_width,
    input  logic [RGBA_BITS-1:0]         rgba,
    input  logic                         full,
    output logic                         push,
    output item_t                        item
);

    assign ready = !full;
    assign push  = valid && !full;

    // Directions of the segment and, for connected segments, its neighbors.
    always_comb
    begin
        item.kind  = kind;
        item.p1x   = COORD_MAX'(start_x);
        item.p1y   = COORD_MAX'(start_y);
        item.p2x   = COORD_MAX'(end_x);
        item.p2y   = COORD_MAX'(end_y);
        item.d0x   = VEC_BITS'(end_x) - VEC_BITS'(start_x);
        item.d0y   = VEC_BITS'(end_y) - VEC_BITS'(start_y);
        item.width = stroke_width;
        item.rgba  = rgba;
        if (kind == KIND_CONNECTED)
        begin
            item.d1x = VEC_BITS'(start_x) - VEC_BITS'(before_x);
            item.d1y = VEC_BITS'(start_y) - VEC_BITS'(before_y);
            item.d2x = VEC_BITS'(after_x) - VEC_BITS'(end_x);
            item.d2y = VEC_BITS'(after_y) - VEC_BITS'(end_y);
        end
        else
        begin
            item.d1x = '0;
            item.d1y = '0;
            item.d2x = '0;
            item.d2y = '0;
        end
    end

endmodule

// ===== hw/rtl/tss_queue.sv =====
// Short queue of classified segments between the front and back ends.
`timescale 1ns / 1ps
module tss_queue
    import tss_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output logic  full,
    output logic  not_empty,
    output item_t head
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    item_t                entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg;
    logic [PTR_BITS-1:0]  rd_ptr_reg;
    logic [PTR_BITS:0]    count_reg;

    assign full      = (count_reg == (PTR_BITS + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/tss_back.sv =====
// Back end: normalizes the directions, scales the half offsets, emits vertices.
`timescale 1ns / 1ps
module tss_back
    import tss_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  item_t                        q_head,
    output logic                         q_pop,
    output logic                         norm_start,
    output logic signed [VEC_BITS-1:0]   norm_x,
    output logic signed [VEC_BITS-1:0]   norm_y,
    input  norm_result_t                 norm_res,
    input  logic signed [COORD_BITS-1:0] offset_x,
    input  logic signed [COORD_BITS-1:0] offset_y,
    output logic                         valid,
    input  logic                         ready,
    output logic signed [COORD_BITS-1:0] vertex_x,
    output logic signed [COORD_BITS-1:0] vertex_y,
    output logic [RGBA_BITS-1:0]         vertex_rgba,
    output logic                         degenerate,
    output logic                         last
);

    localparam int SHIFT     = UNIT_FRAC + WIDTH_FRAC + 1 - FRAC_BITS;
    localparam int PROD_BITS = WIDTH_BITS + Q_BITS;
    localparam int OFF_BITS  = PROD_BITS - SHIFT + 1;
    localparam int SUM_BITS  = ((COORD_BITS > OFF_BITS) ? COORD_BITS : OFF_BITS) + 2;
    localparam logic [PROD_BITS-1:0] ROUND = PROD_BITS'(1) << (SHIFT - 1);
    localparam logic signed [SUM_BITS-1:0] SAT_HI = (SUM_BITS'(1) << (COORD_BITS - 1)) - 1;
    localparam logic signed [SUM_BITS-1:0] SAT_LO = -(SUM_BITS'(1) << (COORD_BITS - 1));
    localparam logic [2:0] STEP_LAST = 3'd4;

    back_state_t state_reg;
    back_state_t state_next;

    item_t                        item_reg;
    logic [2:0]                   step_reg;
    logic                         ok_reg;
    logic signed [UNIT_BITS-1:0]  ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic signed [UNIT_BITS-1:0]  n1x_reg, n1y_reg, n2x_reg, n2y_reg;
    logic signed [OFF_BITS-1:0]   o1x_reg, o1y_reg, o2x_reg, o2y_reg;
    logic [1:0]                   hcnt_reg;
    logic [VCNT_BITS-1:0]         vcnt_reg;
    logic                         out_valid_reg;

    logic                         norm_final;
    logic                         slot_free;
    logic signed [UNIT_BITS-1:0]  rot_x;
    logic signed [UNIT_BITS-1:0]  rot_y;
    logic signed [UNIT_BITS-1:0]  n_sel;
    logic [Q_BITS-1:0]            n_mag;
    logic [PROD_BITS-1:0]         prod;
    logic [OFF_BITS-1:0]          off_mag;
    logic signed [OFF_BITS-1:0]   off_val;
    logic                         use_p2;
    logic                         add_off;
    logic signed [SUM_BITS-1:0]   px, py, ox, oy, sx, sy;

    assign slot_free = !out_valid_reg || ready;
    assign valid     = out_valid_reg;

    // Last normalization of the item: one for plain, five for connected.
    assign norm_final = (item_reg.kind == KIND_PLAIN) || (step_reg == STEP_LAST);

    // Perpendicular (-y, x) of the fresh unit vector.
    assign rot_x = -norm_res.uy;
    assign rot_y = norm_res.ux;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = B_KICK;
                end
            end
            B_KICK: state_next = B_WAIT;
            B_WAIT:
            begin
                if (norm_res.done)
                begin
                    state_next = norm_final ? B_HALF : B_KICK;
                end
            end
            B_HALF:
            begin
                if (hcnt_reg == 2'd3)
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (slot_free && (vcnt_reg == VCNT_BITS'(VERTS - 1)))
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        q_pop      = (state_reg == B_IDLE) && q_valid;
        norm_start = (state_reg == B_KICK);
    end

    // Vector fed to the normalizer for each step.
    always_comb
    begin
        case (step_reg)
            3'd0:
            begin
                norm_x = item_reg.d0x;
                norm_y = item_reg.d0y;
            end
            3'd1:
            begin
                norm_x = item_reg.d1x;
                norm_y = item_reg.d1y;
            end
            3'd2:
            begin
                norm_x = item_reg.d2x;
                norm_y = item_reg.d2y;
            end
            3'd3:
            begin
                norm_x = VEC_BITS'(bx_reg) + VEC_BITS'(ax_reg);
                norm_y = VEC_BITS'(by_reg) + VEC_BITS'(ay_reg);
            end
            default:
            begin
                norm_x = VEC_BITS'(ax_reg) + VEC_BITS'(cx_reg);
                norm_y = VEC_BITS'(ay_reg) + VEC_BITS'(cy_reg);
            end
        endcase
    end

    // Half offset: width times normal component, rounded.
    always_comb
    begin
        case (hcnt_reg)
            2'd0:    n_sel = n1x_reg;
            2'd1:    n_sel = n1y_reg;
            2'd2:    n_sel = n2x_reg;
            default: n_sel = n2y_reg;
        endcase
        n_mag   = n_sel[UNIT_BITS-1] ? Q_BITS'(-n_sel) : Q_BITS'(n_sel);
        prod    = PROD_BITS'(item_reg.width) * PROD_BITS'(n_mag) + ROUND;
        off_mag = OFF_BITS'(prod >> SHIFT);
        off_val = n_sel[UNIT_BITS-1] ? -off_mag : off_mag;
    end

    // Vertex order: p1-o1, p2-o2, p2+o2, p2+o2, p1+o1, p1-o1.
    always_comb
    begin
        case (vcnt_reg)
            3'd1:
            begin
                use_p2  = 1'b1;
                add_off = 1'b0;
            end
            3'd2, 3'd3:
            begin
                use_p2  = 1'b1;
                add_off = 1'b1;
            end
            3'd4:
            begin
                use_p2  = 1'b0;
                add_off = 1'b1;
            end
            default:
            begin
                use_p2  = 1'b0;
                add_off = 1'b0;
            end
        endcase
        px = use_p2 ? SUM_BITS'(item_reg.p2x) : SUM_BITS'(item_reg.p1x);
        py = use_p2 ? SUM_BITS'(item_reg.p2y) : SUM_BITS'(item_reg.p1y);
        ox = use_p2 ? SUM_BITS'(o2x_reg) : SUM_BITS'(o1x_reg);
        oy = use_p2 ? SUM_BITS'(o2y_reg) : SUM_BITS'(o1y_reg);
        sx = (add_off ? px + ox : px - ox) + SUM_BITS'(offset_x);
        sy = (add_off ? py + oy : py - oy) + SUM_BITS'(offset_y);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_EMIT && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                item_reg <= q_head;
                step_reg <= '0;
                ok_reg   <= 1'b1;
            end
            B_WAIT:
            begin
                if (norm_res.done)
                begin
                    ok_reg <= ok_reg && norm_res.nonzero;
                    case (step_reg)
                        3'd0:
                        begin
                            ax_reg  <= norm_res.ux;
                            ay_reg  <= norm_res.uy;
                            n1x_reg <= rot_x;
                            n1y_reg <= rot_y;
                            n2x_reg <= rot_x;
                            n2y_reg <= rot_y;
                        end
                        3'd1:
                        begin
                            bx_reg <= norm_res.ux;
                            by_reg <= norm_res.uy;
                        end
                        3'd2:
                        begin
                            cx_reg <= norm_res.ux;
                            cy_reg <= norm_res.uy;
                        end
                        3'd3:
                        begin
                            n1x_reg <= rot_x;
                            n1y_reg <= rot_y;
                        end
                        default:
                        begin
                            n2x_reg <= rot_x;
                            n2y_reg <= rot_y;
                        end
                    endcase
                    step_reg <= step_reg + 1'b1;
                    hcnt_reg <= '0;
                end
            end
            B_HALF:
            begin
                case (hcnt_reg)
                    2'd0:    o1x_reg <= off_val;
                    2'd1:    o1y_reg <= off_val;
                    2'd2:    o2x_reg <= off_val;
                    default: o2y_reg <= off_val;
                endcase
                hcnt_reg <= hcnt_reg + 1'b1;
                vcnt_reg <= '0;
            end
            B_EMIT:
            begin
                if (slot_free)
                begin
                    vertex_x    <= (sx > SAT_HI) ? COORD_BITS'(SAT_HI)
                                 : (sx < SAT_LO) ? COORD_BITS'(SAT_LO) : COORD_BITS'(sx);
                    vertex_y    <= (sy > SAT_HI) ? COORD_BITS'(SAT_HI)
                                 : (sy < SAT_LO) ? COORD_BITS'(SAT_LO) : COORD_BITS'(sy);
                    vertex_rgba <= item_reg.rgba;
                    degenerate  <= !ok_reg;
                    last        <= (vcnt_reg == VCNT_BITS'(VERTS - 1));
                    vcnt_reg    <= vcnt_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/thick_segment_stroker.sv =====
// Thick segment stroker: turns one line segment into six triangle vertices.
//
// Input channel (valid/ready): one beat per segment with its end points,
// neighbor points, stroke width and color. A two-entry queue decouples the
// input from the arithmetic, so ready stays high until the queue fills.
// Output channel (valid/ready): six vertex beats per segment, the sixth
// flagged by last. Vertices wait in an output register; a stall there holds
// the back end but not the input until the queue is full.
// Configuration channel (valid/ready, always ready): index 0 writes offset_x,
// index 1 writes offset_y; other indexes are ignored. Write only while idle.
// Every segment runs through the shared iterative normalizer (squares,
// 32-step square root, 15-step divider): once for a plain segment, five
// times for a connected one. The back end finishes one segment before it
// pops the next from the queue; an accepted beat passes the queue, the
// normalizations and the half offsets before its first vertex.
// Reset clears the queue, the sequencers and both offsets; no output is
// pending afterwards.
`timescale 1ns / 1ps
module thick_segment_stroker
    import tss_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         kind,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic signed [COORD_BITS-1:0] before_x,
    input  logic signed [COORD_BITS-1:0] before_y,
    input  logic signed [COORD_BITS-1:0] after_x,
    input  logic signed [COORD_BITS-1:0] after_y,
    input  logic [WIDTH_BITS-1:0]        stroke_width,
    input  logic [RGBA_BITS-1:0]         rgba,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] vertex_x,
    output logic signed [COORD_BITS-1:0] vertex_y,
    output logic [RGBA_BITS-1:0]         vertex_rgba,
    output logic                         degenerate,
    output logic                         last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [REG_IDX_BITS-1:0]      cfg_index,
    input  logic [COORD_BITS-1:0]        cfg_data
);

    logic signed [COORD_BITS-1:0] offset_x_reg;
    logic signed [COORD_BITS-1:0] offset_y_reg;

    logic                         push;
    item_t                        push_item;
    logic                         full;
    logic                         not_empty;
    item_t                        head;
    logic                         pop;
    logic                         norm_start;
    logic signed [VEC_BITS-1:0]   norm_x;
    logic signed [VEC_BITS-1:0]   norm_y;
    norm_result_t                 norm_res;

    // Offset registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_OFFSET_X)
            begin
                offset_x_reg <= cfg_data;
            end
            else if (cfg_index == REG_OFFSET_Y)
            begin
                offset_y_reg <= cfg_data;
            end
        end
    end

    tss_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .valid        (in_valid),
        .ready        (in_ready),
        .kind         (kind),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .before_x     (before_x),
        .before_y     (before_y),
        .after_x      (after_x),
        .after_y      (after_y),
        .stroke_width (stroke_width),
        .rgba         (rgba),
        .full         (full),
        .push         (push),
        .item         (push_item)
    );

    tss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    tss_norm u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (norm_start),
        .vec_x  (norm_x),
        .vec_y  (norm_y),
        .result (norm_res)
    );

    tss_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (not_empty),
        .q_head      (head),
        .q_pop       (pop),
        .norm_start  (norm_start),
        .norm_x      (norm_x),
        .norm_y      (norm_y),
        .norm_res    (norm_res),
        .offset_x    (offset_x_reg),
        .offset_y    (offset_y_reg),
        .valid       (out_valid),
        .ready       (out_ready),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .vertex_rgba (vertex_rgba),
        .degenerate  (degenerate),
        .last        (last)
    );

endmodule

// ===== hw/rtl/tss_checker.sv =====
// Port-level checker for the thick segment stroker, bound to the top level.
`timescale 1ns / 1ps
module tss_checker
    import tss_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [COORD_BITS-1:0] vertex_x,
    input logic [RGBA_BITS-1:0]         vertex_rgba,
    input logic                         degenerate,
    input logic                         last
);

    logic [VCNT_BITS-1:0] beat_reg;
    logic [RGBA_BITS-1:0] rgba_reg;
    logic                 deg_reg;
    logic                 out_fire;

    assign out_fire = out_valid && out_ready;

    // Beat position within the current segment.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= '0;
        end
        else if (out_fire)
        begin
            beat_reg <= last ? '0 : beat_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire)
        begin
            rgba_reg <= vertex_rgba;
            deg_reg  <= degenerate;
        end
    end

    // A stalled vertex stays valid with its x coordinate and last flag held.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(vertex_x) && $stable(last))
        else $error("vertex changed while stalled");

    // Last marks exactly the sixth beat.
    a_last_sixth: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> (last == (beat_reg == VCNT_BITS'(VERTS - 1))))
        else $error("last not on the sixth vertex");

    // Color holds across the six beats of one segment.
    a_rgba_same: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && (beat_reg != '0) |-> vertex_rgba == rgba_reg)
        else $error("color changed within a segment");

    // Degenerate flag holds across the six beats of one segment.
    a_deg_same: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && (beat_reg != '0) |-> degenerate == deg_reg)
        else $error("degenerate flag changed within a segment");

endmodule

bind thick_segment_stroker tss_checker #(
    .COORD_BITS (COORD_BITS)
) u_tss_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .vertex_x    (vertex_x),
    .vertex_rgba (vertex_rgba),
    .degenerate  (degenerate),
    .last        (last)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the thick segment stroker.
`timescale 1ns / 1ps

// Scoreboard: predicts the six vertices of each accepted segment and
// checks every vertex beat against the oldest prediction.
class stroke_scoreboard;
    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic [31:0]        rgba;
        logic               degenerate;
        logic               last;
    } vertex_t;

    vertex_t pending_verts[$];
    longint  off_x;
    longint  off_y;
    int      errors;
    int      checked;
    int      degenerate_segs;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Unit vector with 14 fraction bits; returns 0 on a zero-length vector.
    function automatic bit unit_dir(longint dx, longint dy, output longint ux,
                                    output longint uy);
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned len;
        longint unsigned qx;
        longint unsigned qy;
        ux = 0;
        uy = 0;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax == 0 && ay == 0)
            return 0;
        while (ax >= (64'd1 << 31) || ay >= (64'd1 << 31))
        begin
            ax >>= 1;
            ay >>= 1;
        end
        len = int_sqrt(ax * ax + ay * ay);
        qx = ((ax << 14) + (len >> 1)) / len;
        qy = ((ay << 14) + (len >> 1)) / len;
        ux = (dx < 0) ? -longint'(qx) : longint'(qx);
        uy = (dy < 0) ? -longint'(qy) : longint'(qy);
        return 1;
    endfunction

    // Half offset component: width (Q8.8) times unit normal, scaled to Q15.8.
    function automatic longint half_offset(longint w, longint n);
        longint unsigned p;
        p = (w * ((n < 0) ? -n : n) + (64'd1 << 14)) >> 15;
        return (n < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic signed [23:0] clamp(longint v);
        if (v > 64'sd8388607)
            v = 8388607;
        if (v < -64'sd8388608)
            v = -8388608;
        return v[23:0];
    endfunction

    function void set_offset(int idx, logic [23:0] data);
        if (idx == tss_pkg::REG_OFFSET_X)
            off_x = longint'($signed(data));
        else if (idx == tss_pkg::REG_OFFSET_Y)
            off_y = longint'($signed(data));
    endfunction

    // Work out the six vertices of one accepted segment.
    function void note_segment(logic kind, logic signed [23:0] sx, logic signed [23:0] sy,
                               logic signed [23:0] ex, logic signed [23:0] ey,
                               logic signed [23:0] bx, logic signed [23:0] by,
                               logic signed [23:0] fx, logic signed [23:0] fy,
                               logic [15:0] w, logic [31:0] rgba);
        longint dx, dy, px, py, nx, ny;
        longint n1x, n1y, n2x, n2y, o1x, o1y, o2x, o2y;
        longint vx[6];
        longint vy[6];
        bit ok;
        vertex_t v;
        ok = unit_dir(longint'(ex) - sx, longint'(ey) - sy, dx, dy);
        if (kind == tss_pkg::KIND_PLAIN)
        begin
            n1x = -dy;
            n1y = dx;
            n2x = n1x;
            n2y = n1y;
        end
        else
        begin
            ok &= unit_dir(longint'(sx) - bx, longint'(sy) - by, px, py);
            ok &= unit_dir(longint'(fx) - ex, longint'(fy) - ey, nx, ny);
            ok &= unit_dir(px + dx, py + dy, n1x, n1y);
            ok &= unit_dir(dx + nx, dy + ny, n2x, n2y);
            {n1x, n1y} = {-n1y, n1x};
            {n2x, n2y} = {-n2y, n2x};
        end
        o1x = half_offset(w, n1x);
        o1y = half_offset(w, n1y);
        o2x = half_offset(w, n2x);
        o2y = half_offset(w, n2y);
        vx[0] = sx - o1x; vy[0] = sy - o1y;
        vx[1] = ex - o2x; vy[1] = ey - o2y;
        vx[2] = ex + o2x; vy[2] = ey + o2y;
        vx[3] = ex + o2x; vy[3] = ey + o2y;
        vx[4] = sx + o1x; vy[4] = sy + o1y;
        vx[5] = sx - o1x; vy[5] = sy - o1y;
        if (!ok)
            degenerate_segs++;
        for (int k = 0; k < 6; k++)
        begin
            v.x = clamp(vx[k] + off_x);
            v.y = clamp(vy[k] + off_y);
            v.rgba = rgba;
            v.degenerate = !ok;
            v.last = (k == 5);
            pending_verts.push_back(v);
        end
    endfunction

    function void check_vertex(logic signed [23:0] x, logic signed [23:0] y,
                               logic [31:0] rgba, logic dg, logic lst);
        vertex_t e;
        if (pending_verts.size() == 0)
        begin
            $error("vertex beat with no vertex predicted");
            errors++;
            return;
        end
        e = pending_verts.pop_front();
        checked++;
        if (x !== e.x)
        begin
            $error("vertex_x: expected %0d, actual %0d", e.x, x);
            errors++;
        end
        if (y !== e.y)
        begin
            $error("vertex_y: expected %0d, actual %0d", e.y, y);
            errors++;
        end
        if (rgba !== e.rgba)
        begin
            $error("vertex_rgba: expected %h, actual %h", e.rgba, rgba);
            errors++;
        end
        if (dg !== e.degenerate)
        begin
            $error("degenerate: expected %0b, actual %0b", e.degenerate, dg);
            errors++;
        end
        if (lst !== e.last)
        begin
            $error("last: expected %0b, actual %0b", e.last, lst);
            errors++;
        end
    endfunction
endclass

module tb;
    import tss_pkg::*;

    localparam logic signed [23:0] C_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] C_MIN = 24'sh800000;
    localparam logic [REG_IDX_BITS-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_SPARE_3 = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic kind = 1'b0;
    logic signed [23:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
    logic signed [23:0] before_x = '0, before_y = '0, after_x = '0, after_y = '0;
    logic [15:0] stroke_width = '0;
    logic [31:0] rgba = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [23:0] vertex_x, vertex_y;
    logic [31:0] vertex_rgba;
    logic degenerate, last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [REG_IDX_BITS-1:0] cfg_index = '0;
    logic [23:0] cfg_data = '0;

    stroke_scoreboard sb = new();
    int hold_req = 0;
    bit steady_rx = 0;
    int segs_sent = 0;

    always #6 clk = ~clk;

    thick_segment_stroker u_dut (.*);

    // Output side: check every vertex beat, then choose next ready level.
    initial
    begin : rx_proc
        int stall_left;
        int r;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_vertex(vertex_x, vertex_y, vertex_rgba, degenerate, last);
            r = $urandom_range(0, 99);
            if (hold_req > 0)
            begin
                stall_left = hold_req;
                hold_req = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (steady_rx || r < 70)
                out_ready <= 1'b1;
            else
            begin
                stall_left = (r < 97) ? $urandom_range(0, 3) : $urandom_range(15, 50);
                out_ready <= 1'b0;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_segment(logic k, logic signed [23:0] sx, logic signed [23:0] sy,
                                logic signed [23:0] ex, logic signed [23:0] ey,
                                logic signed [23:0] bx, logic signed [23:0] by,
                                logic signed [23:0] fx, logic signed [23:0] fy,
                                logic [15:0] w, logic [31:0] c, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        start_x <= sx; start_y <= sy; end_x <= ex; end_y <= ey;
        before_x <= bx; before_y <= by; after_x <= fx; after_y <= fy;
        stroke_width <= w;
        rgba <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_segment(k, sx, sy, ex, ey, bx, by, fx, fy, w, c);
        segs_sent++;
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (sb.pending_verts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_offset(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [23:0] near(logic signed [23:0] p, int span);
        return 24'(p + $signed(24'($urandom_range(0, 2 * span))) - span);
    endfunction

    // One random segment: mostly a local path with random content, some noise.
    task automatic send_random(int gap);
        logic signed [23:0] pt[8];
        int span;
        int r;
        r = $urandom_range(0, 99);
        span = ($urandom_range(0, 3) == 0) ? 65536 : 1024;
        pt[0] = 24'($urandom);
        for (int i = 1; i < 8; i++)
            pt[i] = (r < 75) ? near(pt[0], span) : 24'($urandom);
        if (r >= 75 && r < 85)
            pt[$urandom_range(1, 7) & ~1] = pt[0];
        if (r >= 75 && r < 85)
        begin
            pt[2] = pt[0];
            pt[3] = pt[1];
        end
        send_segment(1'($urandom_range(0, 1)), pt[0], pt[1], pt[2], pt[3], pt[4], pt[5],
                     pt[6], pt[7], ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                     16'($urandom_range(0, 2047)), $urandom, gap);
    endtask

    task automatic configure(logic [23:0] ox, logic [23:0] oy);
        wait_drained();
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
    endtask

    initial
    begin : limit_proc
        #36000000;
        $display("thick_segment_stroker test failed");
        $finish;
    end

    initial
    begin : main_proc
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed segments at reset offsets.
        send_segment(KIND_PLAIN, 0, 0, 24'sd2560, 0, 0, 0, 0, 0, 16'd512, 32'h0, 0);
        send_segment(KIND_PLAIN, 100, 100, 100, 100, 5, 5, 9, 9, 16'd256, 32'hFFFFFFFF, 0);
        send_segment(KIND_PLAIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN,
                     16'hFFFF, 32'h12345678, 1);
        send_segment(KIND_PLAIN, C_MIN, C_MIN, C_MAX, C_MAX, 0, 0, 0, 0, 16'hFFFF,
                     32'hA5A55A5A, 0);
        send_segment(KIND_PLAIN, 0, 0, -300, 700, 0, 0, 0, 0, 16'd0, 32'h5A5AA5A5, 0);
        send_segment(KIND_CONNECTED, 0, 0, 2560, 0, -2560, 0, 5120, 0, 16'd768,
                     32'h11223344, 0);
        send_segment(KIND_CONNECTED, 0, 0, 2560, 0, 0, -2560, 2560, 2560, 16'd1024,
                     32'h55667788, 2);
        // Path that doubles back on itself at the end point.
        send_segment(KIND_CONNECTED, 0, 0, 2560, 0, -256, 0, 0, 0, 16'd512, 32'h99AABBCC, 0);
        // Zero-length lead-in and lead-out directions.
        send_segment(KIND_CONNECTED, 40, 40, 900, -900, 40, 40, 900, -900, 16'd300,
                     32'hDDEEFF00, 0);
        send_segment(KIND_CONNECTED, 7, 7, 7, 7, 1, 2, 3, 4, 16'd300, 32'h0F0F0F0F, 0);
        send_segment(KIND_CONNECTED, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN,
                     C_MIN, 16'hFFFF, 32'hF0F0F0F0, 0);
        send_segment(KIND_CONNECTED, C_MAX, 0, C_MIN, 1, C_MIN, C_MAX, C_MAX, C_MIN,
                     16'h8000, 32'h01020304, 0);
        send_segment(KIND_PLAIN, 1, 0, 0, 1, C_MAX, C_MIN, C_MAX, C_MIN, 16'd1, 32'h80, 0);
        send_segment(KIND_PLAIN, 0, 0, 1, 1, 0, 0, 0, 0, 16'h7FFF, 32'h80000000, 0);
        for (int i = 0; i < 80; i++)
            send_random(pick_gap());
        stop_sending();

        // Extreme offsets; spare indexes must leave the offsets alone.
        configure(C_MAX, C_MIN);
        write_reg(REG_SPARE_2, 24'($urandom));
        write_reg(REG_SPARE_3, 24'($urandom));
        send_segment(KIND_PLAIN, C_MAX, C_MIN, 24'(C_MAX - 100), 24'(C_MIN + 100), 0, 0, 0, 0,
                     16'hFFFF, 32'hCAFE0001, 0);
        // Block the receiver long enough for the input queue to fill up.
        hold_req = 800;
        for (int i = 0; i < 8; i++)
            send_random(0);
        for (int i = 0; i < 80; i++)
            send_random(pick_gap());
        stop_sending();

        configure(C_MIN, C_MAX);
        steady_rx = 1;
        for (int i = 0; i < 70; i++)
            send_random(0);
        stop_sending();
        steady_rx = 0;

        configure(24'($urandom), 24'($urandom));
        write_reg(REG_SPARE_2, 24'($urandom));
        for (int i = 0; i < 80; i++)
            send_random(pick_gap());
        stop_sending();
        // Sender waits for the output side to catch up completely.
        wait_drained();
        for (int i = 0; i < 40; i++)
            send_random(pick_gap());
        stop_sending();

        configure(near(0, 4096), near(0, 4096));
        for (int i = 0; i < 90; i++)
            send_random(pick_gap());
        stop_sending();

        wait_drained();
        repeat (300) @(posedge clk);
        $display("Sent %0d segments over five offset settings; checked %0d vertices.",
                 segs_sent, sb.checked);
        $display("%0d segments were degenerate; %0d field mismatches seen.",
                 sb.degenerate_segs, sb.errors);
        if (sb.errors == 0 && sb.pending_verts.size() == 0)
            $display("thick_segment_stroker test passed");
        else
            $display("thick_segment_stroker test failed");
        $finish;
    end
endmodule
